// ----- rtl/pds_pkg.sv -----
package pds_pkg;

   localparam int COORD_BITS     = 16;
   localparam int DIST_BITS      = 2 * COORD_BITS + 1;
   localparam int MAX_POINTS_DEF = 8;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic                         last_point;
   } pds_req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic                         out_last;
   } pds_rsp_type;

   // one stored point together with its squared distance
   typedef struct packed {
      logic [DIST_BITS-1:0]  sq_dist;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } pds_entry_type;

endpackage

// ----- rtl/point_distance_sorter_unit.sv -----
// Point distance sorter.
// Collects a batch of signed 2-D points on the req_ channel, one point per item,
// in arrival order. The item with last_point set closes the batch; the block then
// sorts the held points by ascending x*x+y*y (stable: ties keep arrival order)
// and emits them on the rsp_ channel, out_last set on the final one.
// Up to MAX_POINTS points are held; points arriving with the store full are
// dropped, but a dropped point that carries last_point still closes the batch.
// Phases, n = points held:
//   load  : accept, x square, y square, store write for each point;
//           the shared squarer runs twice per point.
//   sort  : one comparator and one write and one read port on the store;
//           n-1 passes in total, each of load, prime, compares and tail.
//   emit  : per result, a memory read and then an output register load.
// req_stall is high while an accepted point is squared and stored, and from
// the close of a batch until the last result of the batch sits in the output
// register. A stall on rsp_ holds that register and pauses the emit sequencer;
// a finished result can wait there while the next batch is already being loaded.
// Reset (synchronous) empties the batch and drops any pending result; the
// point store itself is not cleared.
module point_distance_sorter_unit #(
   parameter int MAX_POINTS = pds_pkg::MAX_POINTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pds_pkg::pds_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pds_pkg::pds_rsp_type rsp_data
);
   import pds_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_POINTS);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_MULX    = 10'b00_0000_0010,
      ST_MULY    = 10'b00_0000_0100,
      ST_STORE   = 10'b00_0000_1000,
      ST_LOAD0   = 10'b00_0001_0000,
      ST_PRIME   = 10'b00_0010_0000,
      ST_CMP     = 10'b00_0100_0000,
      ST_TAIL    = 10'b00_1000_0000,
      ST_EMIT_RD = 10'b01_0000_0000,
      ST_EMIT_LD = 10'b10_0000_0000
   } pds_state_type;

   // control state
   pds_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] end_ff, end_in;     // last position of the current pass
   logic [IDX_W-1:0] k_ff, k_in;         // compare position, reused as emit index
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   pds_req_type              in_ff, in_in;
   logic [2*COORD_BITS-1:0]  prod_ff;
   logic [2*COORD_BITS-1:0]  acc_ff, acc_in;
   pds_entry_type            carry_ff, carry_in;   // larger-so-far element of a pass
   pds_entry_type            rd_data_ff;
   pds_rsp_type              rsp_data_ff, rsp_data_in;

   pds_entry_type point_store_ff [MAX_POINTS];

   // memory port controls
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   pds_entry_type    mem_wd;
   logic [IDX_W-1:0] rd_addr;

   // shared squarer
   logic [COORD_BITS-1:0]   coord_sel;
   logic [COORD_BITS-1:0]   mul_op;
   logic [2*COORD_BITS-1:0] mul_result;

   logic             req_accept;
   logic             out_free;
   logic [CNT_W-1:0] cnt_m1;
   logic [IDX_W:0]   k_p1;
   logic [IDX_W:0]   k_p2;
   logic [CNT_W:0]   emit_p1;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cnt_m1     = count_ff - CNT_W'(1);
   assign k_p1       = {1'b0, k_ff} + (IDX_W+1)'(1);
   assign k_p2       = {1'b0, k_ff} + (IDX_W+1)'(2);
   assign emit_p1    = (CNT_W+1)'(k_ff) + (CNT_W+1)'(1);

   // square the magnitude of x, then of y
   assign coord_sel  = (state_ff == ST_MULX) ? in_ff.point_x : in_ff.point_y;
   assign mul_op     = coord_sel[COORD_BITS-1] ? (~coord_sel + COORD_BITS'(1)) : coord_sel;
   assign mul_result = mul_op * mul_op;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      end_in       = end_ff;
      k_in         = k_ff;
      in_in        = in_ff;
      acc_in       = acc_ff;
      carry_in     = carry_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_wa       = k_ff;
      mem_wd       = carry_ff;
      rd_addr      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (count_ff == FULL_CNT) begin
                  // store full: drop the point, but honor the batch end
                  if (req_data.last_point) begin
                     end_in   = cnt_m1[IDX_W-1:0];
                     state_in = ST_LOAD0;
                  end
               end else begin
                  in_in    = req_data;
                  state_in = ST_MULX;
               end
            end
         end
         ST_MULX: begin
            state_in = ST_MULY;
         end
         ST_MULY: begin
            acc_in   = prod_ff;
            state_in = ST_STORE;
         end
         ST_STORE: begin
            mem_we   = 1'b1;
            mem_wa   = count_ff[IDX_W-1:0];
            mem_wd   = '{sq_dist: DIST_BITS'(acc_ff) + DIST_BITS'(prod_ff),
                         x:       in_ff.point_x,
                         y:       in_ff.point_y};
            count_in = count_ff + CNT_W'(1);
            if (!in_ff.last_point) begin
               state_in = ST_IDLE;
            end else if (count_ff == '0) begin
               // single point: nothing to sort
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               end_in   = count_ff[IDX_W-1:0];
               state_in = ST_LOAD0;
            end
         end
         ST_LOAD0: begin
            rd_addr  = '0;
            state_in = ST_PRIME;
         end
         ST_PRIME: begin
            carry_in = rd_data_ff;
            rd_addr  = IDX_W'(1);
            k_in     = '0;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            mem_we = 1'b1;
            mem_wa = k_ff;
            if (rd_data_ff.sq_dist < carry_ff.sq_dist) begin
               // carry is strictly farther: move the nearer one down, keep carry
               mem_wd = rd_data_ff;
            end else begin
               mem_wd   = carry_ff;
               carry_in = rd_data_ff;
            end
            if (k_p1 == (IDX_W+1)'(end_ff)) begin
               state_in = ST_TAIL;
            end else begin
               rd_addr = k_p2[IDX_W-1:0];
               k_in    = k_p1[IDX_W-1:0];
            end
         end
         ST_TAIL: begin
            // the farthest element of this pass settles at the end
            mem_we = 1'b1;
            mem_wa = end_ff;
            mem_wd = carry_ff;
            if (end_ff == IDX_W'(1)) begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               end_in   = end_ff - IDX_W'(1);
               state_in = ST_LOAD0;
            end
         end
         ST_EMIT_RD: begin
            rd_addr  = k_ff;
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            rd_addr = k_ff;
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.out_x    = rd_data_ff.x;
               rsp_data_in.out_y    = rd_data_ff.y;
               rsp_data_in.out_last = (emit_p1 == (CNT_W+1)'(count_ff));
               if (emit_p1 == (CNT_W+1)'(count_ff)) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = emit_p1[IDX_W-1:0];
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         end_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         end_ff       <= end_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff       <= in_in;
      prod_ff     <= mul_result;
      acc_ff      <= acc_in;
      carry_ff    <= carry_in;
      rsp_data_ff <= rsp_data_in;
   end

   // point store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_store_ff[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= point_store_ff[rd_addr];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/pds_checker.sv -----
module pds_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input pds_pkg::pds_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input pds_pkg::pds_rsp_type rsp_data
);
   import pds_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or vanished");

   // reset drops any pending result
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a batch end always starts the busy sort and emit phase
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last_point |=> req_stall)
      else $error("block idle after batch end");

   // a new result only appears out of the busy phase
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

endmodule

bind point_distance_sorter_unit pds_checker u_pds_checker (.*);

// ----- verif/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pds_pkg::*;

   localparam int CAPACITY   = pds_pkg::MAX_POINTS_DEF;
   localparam int HOLD_LEN   = 400;   // long receiver hold-off, in cycles
   localparam int SETTLE_LEN = 40;    // quiet cycles after the last result

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   logic        req_stall;
   pds_req_type req_data   = '0;
   logic        rsp_valid;
   logic        rsp_stall  = 1'b0;
   pds_rsp_type rsp_data;

   // Idle rates, in percent of cycles; the sender side is applied in send_point,
   // the receiver side in the result process.
   int send_idle_pct = 14;
   int recv_idle_pct = 48;

   int   mismatch_count = 0;
   logic hold_active    = 1'b0;
   event start_hold;

   // Shadow copy of the batch held by the block, in arrival order.
   logic signed [COORD_BITS-1:0] held_x [CAPACITY];
   logic signed [COORD_BITS-1:0] held_y [CAPACITY];
   int                           held_count = 0;

   // Sorted points still owed by the block, oldest first.
   pds_rsp_type sorted_expect [$];

   point_distance_sorter_unit #(
      .MAX_POINTS(CAPACITY)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run of this stimulus.
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // Squared distance from the origin, formed wide enough never to overflow.
   function automatic longint unsigned dist_sq(input logic signed [COORD_BITS-1:0] px,
                                               input logic signed [COORD_BITS-1:0] py);
      longint wx;
      longint wy;
      wx = px;
      wy = py;
      return longint'(wx * wx + wy * wy);
   endfunction

   // Fold one accepted item into the shadow batch; on the closing item, sort
   // the batch (stable: swap only on strictly farther) and queue the results.
   task automatic predict_sorted_batch(input pds_req_type item);
      logic signed [COORD_BITS-1:0] sx [CAPACITY];
      logic signed [COORD_BITS-1:0] sy [CAPACITY];
      logic signed [COORD_BITS-1:0] tmp;
      pds_rsp_type                  res;
      // store the point unless the batch is already full; a dropped point
      // can still close the batch
      if (held_count < CAPACITY) begin
         held_x[held_count] = item.point_x;
         held_y[held_count] = item.point_y;
         held_count++;
      end
      if (!item.last_point)
         return;
      sx = held_x;
      sy = held_y;
      for (int pass = 0; pass + 1 < held_count; pass++) begin
         for (int k = 0; k + 1 < held_count - pass; k++) begin
            if (dist_sq(sx[k], sy[k]) > dist_sq(sx[k+1], sy[k+1])) begin
               tmp = sx[k]; sx[k] = sx[k+1]; sx[k+1] = tmp;
               tmp = sy[k]; sy[k] = sy[k+1]; sy[k+1] = tmp;
            end
         end
      end
      for (int i = 0; i < held_count; i++) begin
         res.out_x    = sx[i];
         res.out_y    = sy[i];
         res.out_last = (i + 1 == held_count);
         sorted_expect.push_back(res);
      end
      held_count = 0;
   endtask

   // ---------------------------------------------------------------------
   // Result side: check each accepted item, then decide next cycle's stall
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pds_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_expect.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual x=%0d y=%0d last=%0b",
                     $time, rsp_data.out_x, rsp_data.out_y, rsp_data.out_last);
            mismatch_count++;
         end else begin
            want = sorted_expect.pop_front();
            if (rsp_data.out_x !== want.out_x) begin
               $display("%0t: out_x mismatch: expected %0d, actual %0d",
                        $time, want.out_x, rsp_data.out_x);
               mismatch_count++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $display("%0t: out_y mismatch: expected %0d, actual %0d",
                        $time, want.out_y, rsp_data.out_y);
               mismatch_count++;
            end
            if (rsp_data.out_last !== want.out_last) begin
               $display("%0t: out_last mismatch: expected %0b, actual %0b",
                        $time, want.out_last, rsp_data.out_last);
               mismatch_count++;
            end
         end
      end
      // hold the result channel solid during a hold-off, else stall at random
      if (hold_active)
         rsp_stall <= 1'b1;
      else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Count out one long hold-off on the result channel per request.
   initial begin
      forever begin
         @(start_hold);
         @(posedge clock);
         hold_active <= 1'b1;
         repeat (HOLD_LEN) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------

   function automatic pds_req_type make_point(input int px, input int py, input bit last);
      pds_req_type item;
      item.point_x    = px[COORD_BITS-1:0];
      item.point_y    = py[COORD_BITS-1:0];
      item.last_point = last;
      return item;
   endfunction

   // Offer one item and hold it until accepted. Valid is left high on return,
   // so a following item can go out on the very next edge.
   task automatic send_point(input pds_req_type item);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_sorted_batch(item);
   endtask

   // Drop valid and wait until every owed result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sorted_expect.size() != 0);
   endtask

   function automatic int rand_coord();
      case ($urandom_range(9))
         0:       return -(1 << (COORD_BITS - 1));
         1:       return (1 << (COORD_BITS - 1)) - 1;
         2, 3:    return int'($urandom_range(8)) - 4;   // small values make ties likely
         default: return int'($urandom_range((1 << COORD_BITS) - 1));
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   task automatic test_single_point();
      send_point(make_point(-32768, -32768, 1'b1));
   endtask

   // Extremes of both coordinates, roughly farthest first so most pairs swap;
   // the two points on the axes at -32768 tie and must keep their order.
   task automatic test_extreme_coords();
      send_point(make_point( 32767,  32767, 1'b0));
      send_point(make_point(-32768, -32768, 1'b0));
      send_point(make_point(-32768,      0, 1'b0));
      send_point(make_point(     0, -32768, 1'b0));
      send_point(make_point( 32767,      0, 1'b0));
      send_point(make_point(    -1,     -1, 1'b0));
      send_point(make_point(     0,      0, 1'b1));
   endtask

   // Every point at distance 5: arrival order must come back unchanged.
   task automatic test_equal_distances();
      send_point(make_point( 3,  4, 1'b0));
      send_point(make_point( 5,  0, 1'b0));
      send_point(make_point(-4, -3, 1'b0));
      send_point(make_point( 0, -5, 1'b0));
      send_point(make_point( 4,  3, 1'b0));
      send_point(make_point(-5,  0, 1'b1));
   endtask

   // Fill the batch, then close it with a point that is itself dropped.
   task automatic test_batch_overflow();
      for (int i = 0; i < CAPACITY; i++)
         send_point(make_point(rand_coord(), rand_coord(), 1'b0));
      send_point(make_point(1, 1, 1'b1));
   endtask

   // Hold the result channel for a long stretch while two full batches are
   // offered back to back, so the block backs up into its input.
   task automatic test_output_backpressure();
      -> start_hold;
      for (int b = 0; b < 2; b++)
         for (int i = 0; i < CAPACITY; i++)
            send_point(make_point(rand_coord(), rand_coord(), i == CAPACITY - 1));
      wait_drained();
   endtask

   // Close a batch, then pause the sender until all results are back.
   task automatic test_pause_until_drained();
      for (int i = 0; i < 4; i++)
         send_point(make_point(rand_coord(), rand_coord(), i == 3));
      wait_drained();
   endtask

   // Random batches, mostly within capacity, now and then overflowing.
   task automatic test_random_batches(input int n_items, input int s_pct, input int r_pct);
      int sent;
      int size;
      @(posedge clock);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 10)
            size = $urandom_range(CAPACITY + 3, CAPACITY + 1);
         else
            size = $urandom_range(CAPACITY, 1);
         for (int i = 0; i < size; i++)
            send_point(make_point(rand_coord(), rand_coord(), i == size - 1));
         sent += size;
      end
      wait_drained();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_point();
      test_extreme_coords();
      test_equal_distances();
      test_batch_overflow();
      wait_drained();
      test_output_backpressure();
      test_pause_until_drained();

      test_random_batches(50, 14, 48);
      test_random_batches(50, 48, 14);
      test_random_batches(50,  0,  0);

      // let any stray result show up before judging the run
      repeat (SETTLE_LEN) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pds_pkg.sv
rtl/point_distance_sorter_unit.sv
rtl/pds_checker.sv
verif/testbench.sv
